// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file of the receiver.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, clocked, disabled while the synchronous reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: lbl");

// Concurrent assertion, clocked, also checked during reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed: lbl");

`endif

// ===== rtl/frs_crc_pkg.sv =====
// Shared types, constants and the CRC-16/MODBUS byte update for the
// framed serial receiver. No dependencies.
package frs_crc_pkg;

    // Frame and CRC constants
    localparam logic [15:0] CRC_INIT      = 16'hFFFF;
    localparam logic [15:0] CRC_POLY      = 16'hA001;
    localparam logic [7:0]  HDR_BYTE0     = 8'h53;  // 'S'
    localparam logic [7:0]  HDR_BYTE1     = 8'h54;  // 'T'
    localparam logic [7:0]  HDR_BYTE2     = 8'h3C;  // '<'
    localparam logic [7:0]  TRL_BYTE0     = 8'h3E;  // '>'
    localparam logic [7:0]  TRL_BYTE1     = 8'h45;  // 'E'
    localparam logic [7:0]  TRL_BYTE2     = 8'h54;  // 'T'
    localparam int          END_MIN_COUNT = 11;
    localparam int          MAX_FRAME_DEF = 256;

    // Field widths and stream data width
    localparam int BYTE_W   = 8;
    localparam int POS_W    = 8;
    localparam int STATUS_W = 2;
    localparam int LEN_W    = 9;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 32;

    // Frame status codes
    localparam logic [STATUS_W-1:0] ST_BUSY     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_COMPLETE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_HDR  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd3;

    // One registered input byte
    typedef struct packed {
        logic              vld;
        logic [BYTE_W-1:0] data;
    } t_in_item;

    // One result item
    typedef struct packed {
        logic [LEN_W-1:0]    frame_length;
        logic [STATUS_W-1:0] frame_status;
        logic [POS_W-1:0]    byte_position;
        logic [BYTE_W-1:0]   byte_out;
    } t_result;

    // CRC-16/MODBUS, reflected, one byte
    function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                 input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/frs_in_stage.sv =====
// Input register of the framed serial receiver: captures one byte per
// transfer. Depends on frs_crc_pkg.
module frs_in_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_tvalid,
    output logic                         o_tready,
    input  logic [frs_crc_pkg::BYTE_W-1:0] i_tdata,
    input  logic                         i_take,
    output frs_crc_pkg::t_in_item        o_item
);

    logic                           r_vld;
    logic [frs_crc_pkg::BYTE_W-1:0] r_data;

    // room when empty or when the held byte moves on this cycle
    assign o_tready = !r_vld || i_take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_tready) begin
            r_vld <= i_tvalid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_tready && i_tvalid) begin
            r_data <= i_tdata;
        end
    end

    assign o_item.vld  = r_vld;
    assign o_item.data = r_data;

endmodule

// ===== rtl/frs_core.sv =====
// Frame state, CRC tracking and result register of the framed serial
// receiver. Depends on frs_crc_pkg.
module frs_core #(
    parameter int MAX_FRAME = frs_crc_pkg::MAX_FRAME_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  frs_crc_pkg::t_in_item i_item,
    output logic                  o_take,
    output logic                  o_valid,
    input  logic                  i_ready,
    output frs_crc_pkg::t_result  o_result
);

    localparam int CW  = $clog2(MAX_FRAME + 1);
    localparam int EXT = (CW > frs_crc_pkg::LEN_W) ? CW : frs_crc_pkg::LEN_W;

    // frame state
    logic [CW-1:0] r_count;
    logic [15:0]   r_crc;
    logic [15:0]   r_crc_hist;
    logic [7:0]    r_recent [4];

    logic                 r_out_valid;
    frs_crc_pkg::t_result r_out;

    logic [CW-1:0]                    w_cnt;
    logic [EXT-1:0]                   w_cnt_ext;
    logic [EXT-1:0]                   w_pos_ext;
    logic [7:0]                       w_b;
    logic                             w_trailer_ok;
    logic [frs_crc_pkg::STATUS_W-1:0] w_status;
    logic [15:0]                      n_crc;

    // result register loads when empty or being drained
    assign o_take = i_item.vld && (!r_out_valid || i_ready);

    assign w_b       = i_item.data;
    assign w_cnt     = r_count + CW'(1);
    assign w_cnt_ext = EXT'(w_cnt);
    assign w_pos_ext = EXT'(r_count);
    assign n_crc     = frs_crc_pkg::crc_add_byte(r_crc, w_b);

    // trailer '>','E','T' then CRC high, low of all bytes before the last two
    assign w_trailer_ok = (r_recent[3] == frs_crc_pkg::TRL_BYTE0) &&
                          (r_recent[2] == frs_crc_pkg::TRL_BYTE1) &&
                          (r_recent[1] == frs_crc_pkg::TRL_BYTE2) &&
                          (r_recent[0] == r_crc_hist[15:8]) &&
                          (w_b == r_crc_hist[7:0]);

    // status decision, header first, completion before overflow
    always_comb begin
        w_status = frs_crc_pkg::ST_BUSY;
        if (w_cnt == CW'(1) && w_b != frs_crc_pkg::HDR_BYTE0) begin
            w_status = frs_crc_pkg::ST_BAD_HDR;
        end else if (w_cnt == CW'(2) && w_b != frs_crc_pkg::HDR_BYTE1) begin
            w_status = frs_crc_pkg::ST_BAD_HDR;
        end else if (w_cnt == CW'(3) && w_b != frs_crc_pkg::HDR_BYTE2) begin
            w_status = frs_crc_pkg::ST_BAD_HDR;
        end else if (w_cnt > CW'(frs_crc_pkg::END_MIN_COUNT) && w_trailer_ok) begin
            w_status = frs_crc_pkg::ST_COMPLETE;
        end else if (w_cnt >= CW'(MAX_FRAME)) begin
            w_status = frs_crc_pkg::ST_OVERFLOW;
        end
    end

    // frame state update, cleared when a frame ends for any reason
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_crc      <= frs_crc_pkg::CRC_INIT;
            r_crc_hist <= frs_crc_pkg::CRC_INIT;
            for (int k = 0; k < 4; k++) begin
                r_recent[k] <= '0;
            end
        end else if (o_take) begin
            if (w_status != frs_crc_pkg::ST_BUSY) begin
                r_count    <= '0;
                r_crc      <= frs_crc_pkg::CRC_INIT;
                r_crc_hist <= frs_crc_pkg::CRC_INIT;
                for (int k = 0; k < 4; k++) begin
                    r_recent[k] <= '0;
                end
            end else begin
                r_count    <= w_cnt;
                r_crc      <= n_crc;
                r_crc_hist <= r_crc;
                r_recent[0] <= w_b;
                for (int k = 1; k < 4; k++) begin
                    r_recent[k] <= r_recent[k-1];
                end
            end
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_take) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out.byte_out      <= w_b;
            r_out.byte_position <= w_pos_ext[frs_crc_pkg::POS_W-1:0];
            r_out.frame_status  <= w_status;
            r_out.frame_length  <= (w_status == frs_crc_pkg::ST_COMPLETE) ?
                                   w_cnt_ext[frs_crc_pkg::LEN_W-1:0] : '0;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/framed_serial_receiver_crc16.sv =====
// Framed serial receiver with CRC-16/MODBUS check, top level.
// Depends on frs_crc_pkg, frs_in_stage and frs_core.
//
// Takes one received byte per transfer and returns one result per byte: the
// byte, its index in the frame, the frame status and, on completion, the
// frame length. A frame opens with 'S','T','<'; from the twelfth byte on it
// completes when '>','E','T' is followed by the CRC-16/MODBUS (high byte
// first) of all bytes before those two. A bad header byte or MAX_FRAME bytes
// without completion discard the frame. One byte is accepted every clock
// cycle while the output side keeps tready high. Each result passes the input
// register, then the CRC byte update and frame checks into the result register,
// before it is offered on the output.
module framed_serial_receiver_crc16 #(
    parameter int MAX_FRAME = frs_crc_pkg::MAX_FRAME_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // [7:0] rx_byte
    input  logic [frs_crc_pkg::S_DATA_W-1:0] s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [7:0] byte_out, [15:8] byte_position, [17:16] frame_status,
    // [26:18] frame_length, [31:27] zero
    output logic [frs_crc_pkg::M_DATA_W-1:0] m_axis_tdata
);

    localparam int RES_W = $bits(frs_crc_pkg::t_result);

    frs_crc_pkg::t_in_item w_item;
    frs_crc_pkg::t_result  w_result;
    logic                  w_take;

    frs_in_stage u_in_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tvalid (s_axis_tvalid),
        .o_tready (s_axis_tready),
        .i_tdata  (s_axis_tdata),
        .i_take   (w_take),
        .o_item   (w_item)
    );

    frs_core #(
        .MAX_FRAME (MAX_FRAME)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_item),
        .o_take   (w_take),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (w_result)
    );

    // result fields packed from the lowest bit up, zero filled
    assign m_axis_tdata = {{(frs_crc_pkg::M_DATA_W - RES_W){1'b0}}, w_result};

endmodule

// ===== rtl/frs_checker.sv =====
// Port-level checker for the framed serial receiver, bound to the top level.
// Depends on frs_crc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module frs_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             s_axis_tvalid,
    input logic                             s_axis_tready,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [frs_crc_pkg::M_DATA_W-1:0] m_axis_tdata
);

    logic [7:0] w_pos;
    logic [1:0] w_status;
    logic [8:0] w_len;
    logic       w_out_stall;
    logic       w_len_ok;
    logic       w_hdr_err;

    assign w_pos    = m_axis_tdata[15:8];
    assign w_status = m_axis_tdata[17:16];
    assign w_len    = m_axis_tdata[26:18];

    assign w_out_stall = m_axis_tvalid && !m_axis_tready;
    assign w_len_ok    = (w_status == frs_crc_pkg::ST_COMPLETE) ? (w_len > 9'd11) :
                                                                 (w_len == 9'd0);
    assign w_hdr_err   = m_axis_tvalid && (w_status == frs_crc_pkg::ST_BAD_HDR);

    // a stalled result holds
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, w_out_stall |=> m_axis_tvalid && $stable(m_axis_tdata))

    // length only on a completed frame, and a frame has at least twelve bytes
    `ASSERT_CLK(a_len_status, i_clk, i_rst_n, m_axis_tvalid |-> w_len_ok)

    // a header error only falls on one of the first three bytes
    `ASSERT_CLK(a_hdr_pos, i_clk, i_rst_n, w_hdr_err |-> w_pos < 8'd3)

    // nothing is offered right after a reset cycle
    `ASSERT_CLK_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> !m_axis_tvalid)

    // the input only holds off while a result waits
    `ASSERT_CLK(a_in_stall, i_clk, i_rst_n, !s_axis_tready |-> w_out_stall)

endmodule

bind framed_serial_receiver_crc16 frs_checker u_frs_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
